FILE: sv/ulf_pkg.sv
// shared types and constants for the utf-8 latin fold to ascii unit
package ulf_pkg;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } ulf_result_t;

    // results produced by one decoded byte, packed from r0 upward
    typedef struct packed {
        logic [1:0]  n;
        ulf_result_t r0;
        ulf_result_t r1;
    } ulf_push_t;

    localparam logic [15:0] CAP_RESET = 16'd256;

    localparam logic [7:0] LEAD_C3   = 8'hC3;
    localparam logic [7:0] LEAD_C2   = 8'hC2;
    localparam logic [7:0] LEAD_E2   = 8'hE2;
    localparam logic [7:0] SEC_80    = 8'h80;
    localparam logic [7:0] SEC_B0    = 8'hB0;
    localparam logic [7:0] PUNCT_LSQ = 8'h98;
    localparam logic [7:0] PUNCT_RSQ = 8'h99;
    localparam logic [7:0] PUNCT_LDQ = 8'h9C;
    localparam logic [7:0] PUNCT_RDQ = 8'h9D;
    localparam logic [7:0] PUNCT_ELL = 8'hA6;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_O     = 7'h6F;
    localparam logic [6:0] CH_APOS  = 7'h27;
    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_NUL   = 7'h00;

    // second byte 80..bf after c3, indexed by its low six bits
    localparam logic [0:63][7:0] LATIN_ROM = {
        "AAAAAAACEEEEIIII",
        "DNOOOOOxOUUUUYPB",
        "aaaaaaaceeeeiiii",
        "dnooooo/ouuuuypy"
    };

endpackage

FILE: sv/ulf_if.sv
// stream interfaces for source bytes and folded characters
interface ulf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ulf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       is_last;

    modport source (output valid, output ascii_char, output is_last, input ready);
    modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface

FILE: sv/ulf_apb_regs.sv
// apb configuration register holding the output capacity
module ulf_apb_regs
    import ulf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] capacity
);

    localparam logic [1:0] ADDR_CAPACITY = 2'd0;

    logic [15:0] capacity_reg;
    logic [15:0] capacity_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_en)
        begin
            capacity_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata   = (paddr == ADDR_CAPACITY) ? {16'd0, capacity_reg} : 32'd0;
    assign capacity = capacity_reg;

endmodule

FILE: sv/ulf_decode.sv
// input register, decode state and per-byte folding logic
module ulf_decode
    import ulf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ulf_in_if.sink      text,
    input  logic [15:0] capacity,
    input  logic        room,
    output ulf_push_t   push
);

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_C3     = 3'd1,
        M_C2     = 3'd2,
        M_E2     = 3'd3,
        M_E2_80  = 3'd4,
        M_SKIP   = 3'd5
    } mode_t;

    typedef struct packed {
        logic       want;
        logic [6:0] ch;
        mode_t      mode;
    } fresh_t;

    function automatic fresh_t fresh_byte(input logic [7:0] b);
        fresh_t f;
        f.want = 1'b0;
        f.ch   = CH_QMARK;
        f.mode = M_IDLE;
        if (!b[7])
        begin
            f.want = 1'b1;
            f.ch   = (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] : CH_SPACE;
        end
        else if (b == LEAD_C3)
        begin
            f.mode = M_C3;
        end
        else if (b == LEAD_C2)
        begin
            f.mode = M_C2;
        end
        else if (b == LEAD_E2)
        begin
            f.mode = M_E2;
        end
        else
        begin
            f.want = 1'b1;
            f.mode = M_SKIP;
        end
        return f;
    endfunction

    function automatic logic [6:0] punct_map(input logic [7:0] b);
        logic [6:0] c;
        case (b) inside
            PUNCT_LSQ, PUNCT_RSQ: c = CH_APOS;
            PUNCT_LDQ, PUNCT_RDQ: c = CH_QUOTE;
            PUNCT_ELL:            c = CH_DOT;
            default:              c = CH_DASH;
        endcase
        return c;
    endfunction

    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    mode_t       mode_reg, mode_next;
    logic [15:0] count_reg, count_next;

    logic        fire;
    logic        end_item;
    logic        is_cont;
    logic        pending;
    fresh_t      fr;
    logic        want0, want1;
    logic [6:0]  c0, c1;
    logic        e0, e1;
    logic [15:0] cnt1;
    mode_t       mode_dec;

    assign fire       = valid_reg && room;
    assign text.ready = !valid_reg || room;

    assign end_item = end_reg || (byte_reg == 8'd0);
    assign is_cont  = (byte_reg[7:6] == 2'b10);
    assign pending  = (mode_reg == M_C3) || (mode_reg == M_C2) ||
                      (mode_reg == M_E2) || (mode_reg == M_E2_80);
    assign fr       = fresh_byte(byte_reg);

    always_comb
    begin
        want0    = 1'b0;
        want1    = 1'b0;
        c0       = CH_QMARK;
        c1       = CH_QMARK;
        mode_dec = mode_reg;
        if (end_item)
        begin
            want0    = pending;
            mode_dec = M_IDLE;
        end
        else
        begin
            case (mode_reg)
                M_C3:
                begin
                    want0    = 1'b1;
                    c0       = is_cont ? LATIN_ROM[byte_reg[5:0]][6:0] : CH_QMARK;
                    mode_dec = M_IDLE;
                end
                M_C2:
                begin
                    want0    = 1'b1;
                    c0       = (byte_reg == SEC_B0) ? CH_O : CH_SPACE;
                    mode_dec = M_IDLE;
                end
                M_E2:
                begin
                    if (byte_reg == SEC_80)
                    begin
                        mode_dec = M_E2_80;
                    end
                    else
                    begin
                        want0 = 1'b1;
                        if (is_cont)
                        begin
                            mode_dec = M_SKIP;
                        end
                        else
                        begin
                            want1    = fr.want;
                            c1       = fr.ch;
                            mode_dec = fr.mode;
                        end
                    end
                end
                M_E2_80:
                begin
                    want0    = 1'b1;
                    c0       = punct_map(byte_reg);
                    mode_dec = M_IDLE;
                end
                M_SKIP:
                begin
                    if (!is_cont)
                    begin
                        want0    = fr.want;
                        c0       = fr.ch;
                        mode_dec = fr.mode;
                    end
                end
                default:
                begin
                    want0    = fr.want;
                    c0       = fr.ch;
                    mode_dec = fr.mode;
                end
            endcase
        end
    end

    // capacity gating, second character sees the count after the first
    always_comb
    begin
        e0   = want0 && (({1'b0, count_reg} + 17'd1) < {1'b0, capacity});
        cnt1 = count_reg + {15'd0, e0};
        e1   = want1 && (({1'b0, cnt1} + 17'd1) < {1'b0, capacity});
    end

    always_comb
    begin
        push.n  = fire ? ({1'b0, e0} + {1'b0, e1} + {1'b0, end_item}) : 2'd0;
        if (e0)
        begin
            push.r0 = '{ch: c0, last: 1'b0};
        end
        else if (e1)
        begin
            push.r0 = '{ch: c1, last: 1'b0};
        end
        else
        begin
            push.r0 = '{ch: CH_NUL, last: 1'b1};
        end
        if (e0 && e1)
        begin
            push.r1 = '{ch: c1, last: 1'b0};
        end
        else
        begin
            push.r1 = '{ch: CH_NUL, last: 1'b1};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        if (fire)
        begin
            valid_next = 1'b0;
            mode_next  = mode_dec;
            count_next = end_item ? 16'd0 : (cnt1 + {15'd0, e1});
        end
        if (text.valid && text.ready)
        begin
            valid_next = 1'b1;
            byte_next  = text.text_byte;
            end_next   = text.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mode_reg  <= M_IDLE;
            count_reg <= 16'd0;
            byte_reg  <= 8'd0;
            end_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            byte_reg  <= byte_next;
            end_reg   <= end_next;
        end
    end

endmodule

FILE: sv/ulf_out_fifo.sv
// four-entry result queue, two writes and one read per cycle
module ulf_out_fifo
    import ulf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ulf_push_t  push,
    output logic       room,
    output logic [2:0] level,
    ulf_out_if.source  folded
);

    ulf_result_t entry_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  level_reg, level_next;
    logic        pop;
    logic [1:0]  wr_ptr_inc;

    assign pop        = folded.valid && folded.ready;
    assign wr_ptr_inc = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        level_next  = level_reg + {1'b0, push.n} - {2'd0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            level_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.r1;
        end
    end

    assign room              = (level_reg <= 3'd2);
    assign level             = level_reg;
    assign folded.valid      = (level_reg != 3'd0);
    assign folded.ascii_char = entry_reg[rd_ptr_reg].ch;
    assign folded.is_last    = entry_reg[rd_ptr_reg].last;

endmodule

FILE: sv/utf8_latin_fold_to_ascii_unit.sv
// top level of the utf-8 latin fold to ascii unit
//
//  channel   dir   handshake      payload
//  text      in    valid/ready    text_byte[7:0], end_of_text
//  folded    out   valid/ready    ascii_char[6:0], is_last
//  apb       in    psel/penable   paddr[1:0], pwdata[31:0] -> capacity
//
// a byte waits in the input register until the queue has room; its 0..2
// results then enter a four-entry queue that folded reads out in order
// one byte per cycle while each gives at most one result and folded is
// ready; two-result bytes outrun the single read port of the result queue
// reset clears the queue, decode state and count, capacity returns to 256
// text.ready drops only when the queue holds three or more results
module utf8_latin_fold_to_ascii_unit
    import ulf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ulf_in_if.sink      text,
    ulf_out_if.source   folded,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] capacity;
    logic        room;
    logic [2:0]  level;
    ulf_push_t   push;

    ulf_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    ulf_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .capacity (capacity),
        .room     (room),
        .push     (push)
    );

    ulf_out_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .level  (level),
        .folded (folded)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'd4)
        else $error("result queue level out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("results pushed without queue room");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (level == 3'd0) |-> text.ready)
        else $error("input stalled while result queue empty");

    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        (folded.valid && folded.ready && push.n == 2'd0) |=> (level == $past(level) - 3'd1))
        else $error("transaction out did not drain the queue");
`endif

endmodule
